FILE: design/pwbs_pkg.sv
`timescale 1ns / 1ps

package pwbs_pkg;

    // register file
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 48;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_COL_A = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OFF_A = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW_B = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_COL_B = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEF_OFF_B = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERSP_ROW  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PERSP_COL  = 3'd7;

    localparam logic [REG_W-1:0] COEF_ONE  = 48'h0001_0000_0000;
    localparam logic [REG_W-1:0] COEF_ZERO = 48'h0;

    // default geometry
    localparam int DEF_SRC_ROWS    = 256;
    localparam int DEF_SRC_COLS    = 256;
    localparam int DEF_OUT_MAX_DIM = 1024;

    // field widths
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int LOAD_W   = 8;
    localparam int OUT_W    = 10;
    localparam int DIM_W    = 13;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = REG_W + OUT_W + 1;
    localparam int SUM_W    = PROD_W + 2;
    localparam int MAG_W    = SUM_W;
    localparam int WT_W     = FRAC_W + 1;
    localparam int TOP_W    = CH_W + WT_W;
    localparam int BLEND_W  = TOP_W + WT_W;

    localparam logic [SUM_W-1:0] W_ONE = 61'h1_0000_0000;

    typedef struct packed {
        logic [REG_W-1:0] h00;
        logic [REG_W-1:0] h01;
        logic [REG_W-1:0] h02;
        logic [REG_W-1:0] h10;
        logic [REG_W-1:0] h11;
        logic [REG_W-1:0] h12;
        logic [REG_W-1:0] h20;
        logic [REG_W-1:0] h21;
    } coef_t;

    // item sideband that rides along the pipe
    typedef struct packed {
        logic              smp;   // 1 = sample, 0 = load
        logic              ok;    // load in range / sample still inside
        logic [LOAD_W-1:0] lrow;
        logic [LOAD_W-1:0] lcol;
        logic [PIX_W-1:0]  lpix;
    } item_t;

endpackage

FILE: design/pwbs_map.sv
`timescale 1ns / 1ps

module pwbs_map #(
    parameter int SRC_ROWS    = pwbs_pkg::DEF_SRC_ROWS,
    parameter int SRC_COLS    = pwbs_pkg::DEF_SRC_COLS,
    parameter int OUT_MAX_DIM = pwbs_pkg::DEF_OUT_MAX_DIM
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  pwbs_pkg::item_t              in_item,
    input  logic [pwbs_pkg::OUT_W-1:0]   in_row,
    input  logic [pwbs_pkg::OUT_W-1:0]   in_col,
    input  pwbs_pkg::coef_t              cfg,
    output logic                         out_vld,
    output pwbs_pkg::item_t              out_item,
    output logic [pwbs_pkg::MAG_W-1:0]   out_num_a,
    output logic [pwbs_pkg::MAG_W-1:0]   out_num_b,
    output logic [pwbs_pkg::MAG_W-1:0]   out_den
);

    localparam int DW = pwbs_pkg::DIM_W;
    localparam int PW = pwbs_pkg::PROD_W;
    localparam int SW = pwbs_pkg::SUM_W;

    // stage 1: products
    logic                  vld1_reg;
    pwbs_pkg::item_t       item1_reg, item1_next;
    logic signed [PW-1:0]  par_reg, pac_reg, pbr_reg, pbc_reg, pwr_reg, pwc_reg;
    // stage 2: sums
    logic                  vld2_reg;
    pwbs_pkg::item_t       item2_reg;
    logic signed [SW-1:0]  a_reg, b_reg, w_reg;
    // stage 3: magnitudes
    logic                  vld3_reg;
    pwbs_pkg::item_t       item3_reg, item3_next;
    logic [SW-1:0]         ma_reg, mb_reg, mw_reg;

    logic dim_ok, load_ok, bad_a, bad_b;

    always_comb
    begin
        dim_ok  = ({3'b0, in_row} < DW'(OUT_MAX_DIM)) && ({3'b0, in_col} < DW'(OUT_MAX_DIM));
        load_ok = ({5'b0, in_item.lrow} < DW'(SRC_ROWS)) && ({5'b0, in_item.lcol} < DW'(SRC_COLS));
        item1_next    = in_item;
        item1_next.ok = in_item.smp ? dim_ok : load_ok;
    end

    // zero W, or numerator of opposite sign, is outside
    always_comb
    begin
        bad_a = (w_reg == '0) || ((a_reg != '0) && (a_reg[SW-1] != w_reg[SW-1]));
        bad_b = (w_reg == '0) || ((b_reg != '0) && (b_reg[SW-1] != w_reg[SW-1]));
        item3_next    = item2_reg;
        item3_next.ok = item2_reg.ok && (!item2_reg.smp || (!bad_a && !bad_b));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= item1_next;
            par_reg   <= $signed(cfg.h00) * $signed({1'b0, in_row});
            pac_reg   <= $signed(cfg.h01) * $signed({1'b0, in_col});
            pbr_reg   <= $signed(cfg.h10) * $signed({1'b0, in_row});
            pbc_reg   <= $signed(cfg.h11) * $signed({1'b0, in_col});
            pwr_reg   <= $signed(cfg.h20) * $signed({1'b0, in_row});
            pwc_reg   <= $signed(cfg.h21) * $signed({1'b0, in_col});

            item2_reg <= item1_reg;
            a_reg     <= SW'(par_reg) + SW'(pac_reg) + SW'($signed(cfg.h02));
            b_reg     <= SW'(pbr_reg) + SW'(pbc_reg) + SW'($signed(cfg.h12));
            w_reg     <= SW'(pwr_reg) + SW'(pwc_reg) + $signed(pwbs_pkg::W_ONE);

            item3_reg <= item3_next;
            ma_reg    <= a_reg[SW-1] ? SW'(-a_reg) : SW'(a_reg);
            mb_reg    <= b_reg[SW-1] ? SW'(-b_reg) : SW'(b_reg);
            mw_reg    <= w_reg[SW-1] ? SW'(-w_reg) : SW'(w_reg);
        end
    end

    assign out_vld   = vld3_reg;
    assign out_item  = item3_reg;
    assign out_num_a = ma_reg;
    assign out_num_b = mb_reg;
    assign out_den   = mw_reg;

endmodule

FILE: design/pwbs_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, two lanes sharing the divisor.
module pwbs_div #(
    parameter int SRC_ROWS = pwbs_pkg::DEF_SRC_ROWS,
    parameter int SRC_COLS = pwbs_pkg::DEF_SRC_COLS,
    localparam int RB = $clog2(SRC_ROWS),
    localparam int CB = $clog2(SRC_COLS),
    localparam int IB = (RB > CB) ? RB : CB,
    localparam int QW = IB + pwbs_pkg::FRAC_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  pwbs_pkg::item_t              in_item,
    input  logic [pwbs_pkg::MAG_W-1:0]   in_num_a,
    input  logic [pwbs_pkg::MAG_W-1:0]   in_num_b,
    input  logic [pwbs_pkg::MAG_W-1:0]   in_den,
    output logic                         out_vld,
    output pwbs_pkg::item_t              out_item,
    output logic [QW-1:0]                out_quo_a,
    output logic [QW-1:0]                out_quo_b
);

    localparam int MW = pwbs_pkg::MAG_W;
    localparam int RW = MW + pwbs_pkg::FRAC_W;
    localparam int CW = RW + IB;

    logic            vld_reg  [QW+1];
    pwbs_pkg::item_t item_reg [QW+1];
    logic [MW-1:0]   den_reg  [QW+1];
    logic [RW-1:0]   rem_reg  [2][QW+1];
    logic [QW-1:0]   quo_reg  [2][QW+1];

    logic [RW-1:0]   num0 [2];
    logic            pre_ok;
    pwbs_pkg::item_t item0_next;

    // stage 0: integer part must fit in IB bits
    always_comb
    begin
        num0[0] = {in_num_a, {pwbs_pkg::FRAC_W{1'b0}}};
        num0[1] = {in_num_b, {pwbs_pkg::FRAC_W{1'b0}}};
        pre_ok  = (CW'(in_num_a) < (CW'(in_den) << IB)) &&
                  (CW'(in_num_b) < (CW'(in_den) << IB));
        item0_next    = in_item;
        item0_next.ok = in_item.ok && (!in_item.smp || pre_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0]   <= item0_next;
            den_reg[0]    <= in_den;
            rem_reg[0][0] <= num0[0];
            rem_reg[1][0] <= num0[1];
            quo_reg[0][0] <= '0;
            quo_reg[1][0] <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int J = QW - k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= item_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [CW-1:0] dsh;
            logic          take;
            logic [QW-1:0] quo_next;

            always_comb
            begin
                dsh         = CW'(den_reg[k-1]) << J;
                take        = (CW'(rem_reg[l][k-1]) >= dsh);
                quo_next    = quo_reg[l][k-1];
                quo_next[J] = take;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][k] <= take ? RW'(CW'(rem_reg[l][k-1]) - dsh) : rem_reg[l][k-1];
                    quo_reg[l][k] <= quo_next;
                end
            end
        end
    end

    assign out_vld   = vld_reg[QW];
    assign out_item  = item_reg[QW];
    assign out_quo_a = quo_reg[0][QW];
    assign out_quo_b = quo_reg[1][QW];

endmodule

FILE: design/pwbs_interp.sv
`timescale 1ns / 1ps

// Four parity banks of the source image, neighbour fetch, bilinear blend.
module pwbs_interp #(
    parameter int SRC_ROWS = pwbs_pkg::DEF_SRC_ROWS,
    parameter int SRC_COLS = pwbs_pkg::DEF_SRC_COLS,
    localparam int RB = $clog2(SRC_ROWS),
    localparam int CB = $clog2(SRC_COLS),
    localparam int IB = (RB > CB) ? RB : CB,
    localparam int QW = IB + pwbs_pkg::FRAC_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  pwbs_pkg::item_t             in_item,
    input  logic [QW-1:0]               in_quo_a,
    input  logic [QW-1:0]               in_quo_b,
    output logic                        out_vld,
    output logic [pwbs_pkg::PIX_W-1:0]  out_pix,
    output logic                        out_inside
);

    localparam int FW  = pwbs_pkg::FRAC_W;
    localparam int CHW = pwbs_pkg::CH_W;
    localparam int WW  = pwbs_pkg::WT_W;
    localparam int TW  = pwbs_pkg::TOP_W;
    localparam int BW  = pwbs_pkg::BLEND_W;
    localparam int MRB = (RB > pwbs_pkg::LOAD_W) ? pwbs_pkg::LOAD_W : RB;
    localparam int MCB = (CB > pwbs_pkg::LOAD_W) ? pwbs_pkg::LOAD_W : CB;
    localparam int HRB = (MRB > 1) ? MRB - 1 : 1;
    localparam int HCB = (MCB > 1) ? MCB - 1 : 1;
    localparam int AW  = HRB + HCB;
    localparam int BANK_DEPTH = 1 << AW;
    localparam int LOAD_MAX = (1 << pwbs_pkg::LOAD_W) - 1;
    localparam logic [WW-1:0] WT_ONE = WW'(1) << FW;
    localparam logic [BW-1:0] RND    = BW'(1) << (2 * FW - 1);

    // fetch address generation
    logic [IB-1:0]  x0, y0, x1, y1;
    logic [IB:0]    xp, yp, rsel, csel;
    logic [FW-1:0]  xf, yf;
    logic           inside0;
    logic           xhi0, xhi1, yhi0, yhi1;
    logic [HRB-1:0] rhalf [2];
    logic [HCB-1:0] chalf [2];
    logic [AW-1:0]  waddr;
    logic [1:0]     wbank;
    logic           we;

    always_comb
    begin
        x0 = in_quo_a[QW-1:FW];
        xf = in_quo_a[FW-1:0];
        y0 = in_quo_b[QW-1:FW];
        yf = in_quo_b[FW-1:0];
        inside0 = in_item.smp && in_item.ok &&
                  ({1'b0, x0} < (IB+1)'(SRC_ROWS)) && ({1'b0, y0} < (IB+1)'(SRC_COLS));
        xp = {1'b0, x0} + (IB+1)'(1);
        yp = {1'b0, y0} + (IB+1)'(1);
        // upper neighbour clamps to the last row / column
        x1 = (xp < (IB+1)'(SRC_ROWS)) ? xp[IB-1:0] : IB'(SRC_ROWS - 1);
        y1 = (yp < (IB+1)'(SRC_COLS)) ? yp[IB-1:0] : IB'(SRC_COLS - 1);
        // rows and columns past the loadable range read as black
        xhi0 = ({1'b0, x0} > (IB+1)'(LOAD_MAX));
        xhi1 = ({1'b0, x1} > (IB+1)'(LOAD_MAX));
        yhi0 = ({1'b0, y0} > (IB+1)'(LOAD_MAX));
        yhi1 = ({1'b0, y1} > (IB+1)'(LOAD_MAX));
        rsel = '0;
        csel = '0;
        for (int p = 0; p < 2; p++)
        begin
            rsel     = (x0[0] == 1'(p)) ? {1'b0, x0} : xp;
            csel     = (y0[0] == 1'(p)) ? {1'b0, y0} : yp;
            rhalf[p] = HRB'(rsel[MRB-1:0] >> 1);
            chalf[p] = HCB'(csel[MCB-1:0] >> 1);
        end
        wbank = {in_item.lrow[0], in_item.lcol[0]};
        waddr = {HRB'(in_item.lrow[MRB-1:0] >> 1), HCB'(in_item.lcol[MCB-1:0] >> 1)};
        we    = in_vld && !in_item.smp && in_item.ok;
    end

    // stage 1: bank read
    logic [pwbs_pkg::PIX_W-1:0] rd_reg [4];
    logic [1:0]    s00_reg, s01_reg, s10_reg, s11_reg;
    logic [3:0]    hi1_reg;
    logic [FW-1:0] xf1_reg, yf1_reg;
    logic          in1_reg, vld1_reg;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam int RP = b / 2;
        localparam int CP = b % 2;
        logic [pwbs_pkg::PIX_W-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (we && (wbank == 2'(b)))
                begin
                    mem[waddr] <= in_item.lpix;
                end
                rd_reg[b] <= mem[{rhalf[RP], chalf[CP]}];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s00_reg <= {x0[0], y0[0]};
            s01_reg <= {x0[0], y1[0]};
            s10_reg <= {x1[0], y0[0]};
            s11_reg <= {x1[0], y1[0]};
            hi1_reg <= {xhi1 || yhi1, xhi1 || yhi0, xhi0 || yhi1, xhi0 || yhi0};
            xf1_reg <= xf;
            yf1_reg <= yf;
            in1_reg <= inside0;
        end
    end

    // stage 2: blend along columns
    logic [TW-1:0]  top_next [3], bot_next [3];
    logic [TW-1:0]  top_reg [3], bot_reg [3];
    logic [FW-1:0]  xf2_reg;
    logic           in2_reg, vld2_reg;
    logic [WW-1:0]  wy0, wy1;
    logic [pwbs_pkg::PIX_W-1:0] p00, p01, p10, p11;

    always_comb
    begin
        p00 = hi1_reg[0] ? '0 : rd_reg[s00_reg];
        p01 = hi1_reg[1] ? '0 : rd_reg[s01_reg];
        p10 = hi1_reg[2] ? '0 : rd_reg[s10_reg];
        p11 = hi1_reg[3] ? '0 : rd_reg[s11_reg];
        wy1 = {1'b0, yf1_reg};
        wy0 = WT_ONE - wy1;
        for (int c = 0; c < 3; c++)
        begin
            top_next[c] = TW'(p00[c*CHW +: CHW]) * TW'(wy0) + TW'(p01[c*CHW +: CHW]) * TW'(wy1);
            bot_next[c] = TW'(p10[c*CHW +: CHW]) * TW'(wy0) + TW'(p11[c*CHW +: CHW]) * TW'(wy1);
        end
    end

    // stage 3: blend along rows
    logic [BW-1:0]  v_next [3], v_reg [3];
    logic           in3_reg, vld3_reg;
    logic [WW-1:0]  wx0, wx1;

    always_comb
    begin
        wx1 = {1'b0, xf2_reg};
        wx0 = WT_ONE - wx1;
        for (int c = 0; c < 3; c++)
        begin
            v_next[c] = BW'(top_reg[c]) * BW'(wx0) + BW'(bot_reg[c]) * BW'(wx1);
        end
    end

    // stage 4: round, saturate, zero when outside, output register
    logic [pwbs_pkg::PIX_W-1:0] pix_next, pix_reg;
    logic [BW-1:0]              rnd_sum;
    logic [BW-2*FW-1:0]         rnd_hi;
    logic                       vld4_reg, in4_reg;

    always_comb
    begin
        pix_next = '0;
        rnd_sum  = '0;
        rnd_hi   = '0;
        for (int c = 0; c < 3; c++)
        begin
            rnd_sum = v_reg[c] + RND;
            rnd_hi  = rnd_sum[BW-1:2*FW];
            if (!in3_reg)
            begin
                pix_next[c*CHW +: CHW] = '0;
            end
            else if (rnd_hi > (BW-2*FW)'(255))
            begin
                pix_next[c*CHW +: CHW] = 8'hFF;
            end
            else
            begin
                pix_next[c*CHW +: CHW] = rnd_hi[CHW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld && in_item.smp;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            xf2_reg <= xf1_reg;
            in2_reg <= in1_reg;
            v_reg   <= v_next;
            in3_reg <= in2_reg;
            pix_reg <= pix_next;
            in4_reg <= in3_reg;
        end
    end

    assign out_vld    = vld4_reg;
    assign out_pix    = pix_reg;
    assign out_inside = in4_reg;

endmodule

FILE: design/perspective_warp_bilinear_sampler.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Content
// s_axis    in   tvalid/tready           tuser: cmd; tdata: load and sample fields
// m_axis    out  tvalid/tready           tuser: inside_res; tdata: three channels
// cfg       in   cfg_we (no ready)       cfg_addr selects one of eight 48-bit coefficients
//
// One item enters per cycle while s_axis_tready is high. A sample passes through the
// mapping stages, the bit-per-stage divider and the interpolation stages before it
// leaves. Loads write the image in the same order as samples read it and produce
// no output.
// Reset clears the valid bits and the coefficients (h00 = h11 = 1.0); the image is
// not cleared. The whole pipe advances together and holds when the output register
// is full and not taken; s_axis_tready is low only then.
module perspective_warp_bilinear_sampler #(
    parameter int SRC_ROWS    = pwbs_pkg::DEF_SRC_ROWS,
    parameter int SRC_COLS    = pwbs_pkg::DEF_SRC_COLS,
    parameter int OUT_MAX_DIM = pwbs_pkg::DEF_OUT_MAX_DIM
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] load_row, [15:8] load_col, [23:16] load_ch0, [31:24] load_ch1,
    // [39:32] load_ch2, [49:40] out_row, [59:50] out_col, [63:60] zero
    input  logic [63:0]                       s_axis_tdata,
    // [0] cmd
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] pix_ch0, [15:8] pix_ch1, [23:16] pix_ch2
    output logic [23:0]                       m_axis_tdata,
    // [0] inside_res
    output logic                              m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [pwbs_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  logic [pwbs_pkg::REG_W-1:0]        cfg_data
);

    localparam int RB = $clog2(SRC_ROWS);
    localparam int CB = $clog2(SRC_COLS);
    localparam int IB = (RB > CB) ? RB : CB;
    localparam int QW = IB + pwbs_pkg::FRAC_W;

    // coefficient registers
    pwbs_pkg::coef_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.h00 <= pwbs_pkg::COEF_ONE;
            cfg_reg.h01 <= pwbs_pkg::COEF_ZERO;
            cfg_reg.h02 <= pwbs_pkg::COEF_ZERO;
            cfg_reg.h10 <= pwbs_pkg::COEF_ZERO;
            cfg_reg.h11 <= pwbs_pkg::COEF_ONE;
            cfg_reg.h12 <= pwbs_pkg::COEF_ZERO;
            cfg_reg.h20 <= pwbs_pkg::COEF_ZERO;
            cfg_reg.h21 <= pwbs_pkg::COEF_ZERO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pwbs_pkg::REG_COEF_ROW_A: cfg_reg.h00 <= cfg_data;
                pwbs_pkg::REG_COEF_COL_A: cfg_reg.h01 <= cfg_data;
                pwbs_pkg::REG_COEF_OFF_A: cfg_reg.h02 <= cfg_data;
                pwbs_pkg::REG_COEF_ROW_B: cfg_reg.h10 <= cfg_data;
                pwbs_pkg::REG_COEF_COL_B: cfg_reg.h11 <= cfg_data;
                pwbs_pkg::REG_COEF_OFF_B: cfg_reg.h12 <= cfg_data;
                pwbs_pkg::REG_PERSP_ROW:  cfg_reg.h20 <= cfg_data;
                pwbs_pkg::REG_PERSP_COL:  cfg_reg.h21 <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: stall only when the output register holds an untaken result
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    pwbs_pkg::item_t in_item;

    always_comb
    begin
        in_item.smp  = s_axis_tuser;
        in_item.ok   = 1'b0;
        in_item.lrow = s_axis_tdata[7:0];
        in_item.lcol = s_axis_tdata[15:8];
        in_item.lpix = s_axis_tdata[39:16];
    end

    logic                          map_vld;
    pwbs_pkg::item_t               map_item;
    logic [pwbs_pkg::MAG_W-1:0]    map_num_a, map_num_b, map_den;

    pwbs_map #(
        .SRC_ROWS    (SRC_ROWS),
        .SRC_COLS    (SRC_COLS),
        .OUT_MAX_DIM (OUT_MAX_DIM)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (s_axis_tvalid),
        .in_item   (in_item),
        .in_row    (s_axis_tdata[49:40]),
        .in_col    (s_axis_tdata[59:50]),
        .cfg       (cfg_reg),
        .out_vld   (map_vld),
        .out_item  (map_item),
        .out_num_a (map_num_a),
        .out_num_b (map_num_b),
        .out_den   (map_den)
    );

    logic            div_vld;
    pwbs_pkg::item_t div_item;
    logic [QW-1:0]   div_quo_a, div_quo_b;

    pwbs_div #(
        .SRC_ROWS (SRC_ROWS),
        .SRC_COLS (SRC_COLS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (map_vld),
        .in_item   (map_item),
        .in_num_a  (map_num_a),
        .in_num_b  (map_num_b),
        .in_den    (map_den),
        .out_vld   (div_vld),
        .out_item  (div_item),
        .out_quo_a (div_quo_a),
        .out_quo_b (div_quo_b)
    );

    pwbs_interp #(
        .SRC_ROWS (SRC_ROWS),
        .SRC_COLS (SRC_COLS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (div_vld),
        .in_item    (div_item),
        .in_quo_a   (div_quo_a),
        .in_quo_b   (div_quo_b),
        .out_vld    (m_axis_tvalid),
        .out_pix    (m_axis_tdata),
        .out_inside (m_axis_tuser)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the perspective warp bilinear sampler.
// The initial block queues items and predicts each sample as it is queued;
// transfers keep queue order, so the bench image matches the block's image
// at that point. Samples that would read a pixel never loaded are not sent.
// A clocked driver feeds s_axis, a clocked monitor on m_axis checks in order.
module testbench;

    localparam bit CMD_LOAD    = 1'b0;
    localparam bit CMD_SAMPLE  = 1'b1;
    localparam int SETTLE      = 60;      // longer than the sample latency
    localparam int MAX_CYCLES  = 60000;
    localparam int PHASE_ITEMS = 75;
    localparam int MAX_TRIES   = 20000;
    localparam logic [pwbs_pkg::REG_W-1:0] C_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [pwbs_pkg::REG_W-1:0] C_MIN     = 48'h8000_0000_0000;
    localparam logic [pwbs_pkg::REG_W-1:0] C_QUARTER = 48'h0000_4000_0000;
    localparam logic [pwbs_pkg::REG_W-1:0] C_HALF    = 48'h0000_8000_0000;
    localparam logic [pwbs_pkg::REG_W-1:0] C_NEG_ONE = 48'hFFFF_0000_0000;

    typedef struct packed {
        bit       cmd;
        bit [9:0] ocol;
        bit [9:0] orow;
        bit [7:0] ch2;
        bit [7:0] ch1;
        bit [7:0] ch0;
        bit [7:0] lcol;
        bit [7:0] lrow;
    } warp_item_t;

    typedef struct packed {
        bit       in_img;
        bit [7:0] ch2;
        bit [7:0] ch1;
        bit [7:0] ch0;
    } warp_pix_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [63:0]                       s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [23:0]                       m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              cfg_we = 1'b0;
    logic [pwbs_pkg::REG_IDX_W-1:0]    cfg_addr = '0;
    logic [pwbs_pkg::REG_W-1:0]        cfg_data = '0;

    // bench copy of block state
    pwbs_pkg::coef_t homog;
    bit [23:0]  src_img [65536];
    bit         src_set [65536];

    warp_item_t pending_items[$];
    warp_pix_t  expected_pix[$];
    warp_item_t on_bus;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         errors = 0;
    int         cycles = 0;
    int         hold_request = 0;
    int         hold_served = 0;
    int         hold_left = 0;

    perspective_warp_bilinear_sampler DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // floor(n/d) with 16 fraction bits; 1 if 0 <= result < lim
    function automatic bit divide_coord(longint n, longint d, int lim,
                                        output int ipart, output int fpart);
        longint unsigned un, ud, q, rm;
        int f;
        ipart = 0;
        fpart = 0;
        if (d == 0)
            return 1'b0;
        if (n != 0 && ((n < 0) != (d < 0)))
            return 1'b0;
        un = (n < 0) ? longint'(-n) : longint'(n);
        ud = (d < 0) ? longint'(-d) : longint'(d);
        q = un / ud;
        if (q >= longint'(lim))
            return 1'b0;
        rm = un % ud;
        f = 0;
        for (int k = 0; k < 16; k++)
        begin
            rm = rm << 1;
            f = f << 1;
            if (rm >= ud)
            begin
                rm -= ud;
                f |= 1;
            end
        end
        ipart = int'(q);
        fpart = f;
        return 1'b1;
    endfunction

    // unset is 1 when an inside sample would read a pixel never loaded
    function automatic warp_pix_t warp_sample(bit [9:0] orow, bit [9:0] ocol,
                                              output bit unset);
        warp_pix_t px;
        longint r, c, a, b, w;
        int xi, xf, yi, yf, x1, y1;
        bit [23:0] p00, p01, p10, p11;
        longint unsigned v00, v01, v10, v11, top, bot, v;
        px = '0;
        unset = 1'b0;
        r = longint'(orow);
        c = longint'(ocol);
        if (r >= pwbs_pkg::DEF_OUT_MAX_DIM || c >= pwbs_pkg::DEF_OUT_MAX_DIM)
            return px;
        a = longint'($signed(homog.h00)) * r + longint'($signed(homog.h01)) * c
            + longint'($signed(homog.h02));
        b = longint'($signed(homog.h10)) * r + longint'($signed(homog.h11)) * c
            + longint'($signed(homog.h12));
        w = longint'($signed(homog.h20)) * r + longint'($signed(homog.h21)) * c
            + 64'h1_0000_0000;
        if (!divide_coord(a, w, pwbs_pkg::DEF_SRC_ROWS, xi, xf))
            return px;
        if (!divide_coord(b, w, pwbs_pkg::DEF_SRC_COLS, yi, yf))
            return px;
        // upper neighbor clamps at the last row / column
        x1 = (xi + 1 < pwbs_pkg::DEF_SRC_ROWS) ? xi + 1 : pwbs_pkg::DEF_SRC_ROWS - 1;
        y1 = (yi + 1 < pwbs_pkg::DEF_SRC_COLS) ? yi + 1 : pwbs_pkg::DEF_SRC_COLS - 1;
        unset = !(src_set[xi * 256 + yi] && src_set[xi * 256 + y1]
                  && src_set[x1 * 256 + yi] && src_set[x1 * 256 + y1]);
        p00 = src_img[xi * 256 + yi];
        p01 = src_img[xi * 256 + y1];
        p10 = src_img[x1 * 256 + yi];
        p11 = src_img[x1 * 256 + y1];
        for (int ch = 0; ch < 3; ch++)
        begin
            v00 = p00[ch*8 +: 8];
            v01 = p01[ch*8 +: 8];
            v10 = p10[ch*8 +: 8];
            v11 = p11[ch*8 +: 8];
            top = v00 * (65536 - yf) + v01 * yf;
            bot = v10 * (65536 - yf) + v11 * yf;
            v = (top * (65536 - xf) + bot * xf + 64'h8000_0000) >> 32;
            if (v > 255)
                v = 255;
            case (ch)
                0: px.ch0 = v[7:0];
                1: px.ch1 = v[7:0];
                default: px.ch2 = v[7:0];
            endcase
        end
        px.in_img = 1'b1;
        return px;
    endfunction

    // driver: holds an item until its transfer
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= on_bus.cmd;
                    s_axis_tdata <= {4'd0, on_bus.ocol, on_bus.orow, on_bus.ch2,
                                     on_bus.ch1, on_bus.ch0, on_bus.lcol, on_bus.lrow};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request != hold_served)
        begin
            hold_left <= 400;
            hold_served <= hold_request;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        warp_pix_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pix.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel %h inside %b", m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_pix.pop_front();
                    if (m_axis_tdata !== {want.ch2, want.ch1, want.ch0}
                        || m_axis_tuser !== want.in_img)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("pixel exp %h/%b got %h/%b",
                                     {want.ch2, want.ch1, want.ch0}, want.in_img,
                                     m_axis_tdata, m_axis_tuser);
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > MAX_CYCLES)
        begin
            $display("perspective_warp_bilinear_sampler: mismatch");
            $finish;
        end
    end

    task automatic put_load(bit [7:0] row, bit [7:0] col, bit [23:0] pix);
        warp_item_t it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.lrow = row;
        it.lcol = col;
        {it.ch2, it.ch1, it.ch0} = pix;
        pending_items.push_back(it);
        src_img[{row, col}] = pix;
        src_set[{row, col}] = 1'b1;
    endtask

    task automatic put_sample(bit [9:0] row, bit [9:0] col, output bit sent);
        warp_item_t it;
        warp_pix_t  px;
        bit         unset;
        px = warp_sample(row, col, unset);
        sent = !unset;
        if (!unset)
        begin
            it = '0;
            // junk in unused fields
            {it.ch2, it.ch1, it.ch0, it.lcol, it.lrow} = 40'({$urandom, $urandom});
            it.cmd = CMD_SAMPLE;
            it.orow = row;
            it.ocol = col;
            pending_items.push_back(it);
            expected_pix.push_back(px);
        end
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_pix.size() == 0);
        // loads give no output; let any still in the pipe finish
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [pwbs_pkg::REG_IDX_W-1:0] idx,
                             logic [pwbs_pkg::REG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
    endtask

    task automatic apply_homog(pwbs_pkg::coef_t hc);
        write_reg(pwbs_pkg::REG_COEF_ROW_A, hc.h00);
        write_reg(pwbs_pkg::REG_COEF_COL_A, hc.h01);
        write_reg(pwbs_pkg::REG_COEF_OFF_A, hc.h02);
        write_reg(pwbs_pkg::REG_COEF_ROW_B, hc.h10);
        write_reg(pwbs_pkg::REG_COEF_COL_B, hc.h11);
        write_reg(pwbs_pkg::REG_COEF_OFF_B, hc.h12);
        write_reg(pwbs_pkg::REG_PERSP_ROW, hc.h20);
        write_reg(pwbs_pkg::REG_PERSP_COL, hc.h21);
        @(posedge clk);
        cfg_we <= 1'b0;
        homog = hc;
    endtask

    initial
    begin
        pwbs_pkg::coef_t hc;
        int span;
        int made;
        int tries;
        bit sent;
        homog = '{h00: pwbs_pkg::COEF_ONE, h11: pwbs_pkg::COEF_ONE,
                  default: pwbs_pkg::COEF_ZERO};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // top-left block and the three other corners
        for (int rr = 0; rr < 16; rr++)
            for (int cc = 0; cc < 16; cc++)
                put_load(8'(rr), 8'(cc), 24'($urandom));
        for (int rr = 0; rr < 4; rr++)
            for (int cc = 0; cc < 4; cc++)
            begin
                put_load(8'(252 + rr), 8'(cc), 24'($urandom));
                put_load(8'(rr), 8'(252 + cc), 24'($urandom));
                put_load(8'(252 + rr), 8'(252 + cc), 24'($urandom));
            end
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            hc = '{h00: pwbs_pkg::COEF_ONE, h11: pwbs_pkg::COEF_ONE,
                   default: pwbs_pkg::COEF_ZERO};
            span = 15;
            case (ph)
                1:  // quarter scale
                begin
                    hc.h00 = C_QUARTER;
                    hc.h11 = C_QUARTER;
                    span = 63;
                end
                2:  // transpose and mirror with half-pixel offset
                begin
                    hc.h00 = pwbs_pkg::COEF_ZERO;
                    hc.h01 = C_QUARTER;
                    hc.h10 = -C_QUARTER;
                    hc.h11 = pwbs_pkg::COEF_ZERO;
                    hc.h12 = 48'h00FF_8000_0000;
                    span = 15;
                end
                3:  // mild perspective
                begin
                    hc.h00 = C_HALF;
                    hc.h02 = 48'h0001_8000_0000;
                    hc.h20 = 48'h0000_0040_0000;
                    hc.h21 = 48'hFFFF_FFE0_0000;
                    span = 31;
                end
                4:  // coefficient extremes
                begin
                    hc.h00 = C_MAX;
                    hc.h01 = C_MIN;
                    hc.h02 = C_MAX;
                    hc.h10 = C_MIN;
                    hc.h11 = C_MAX;
                    hc.h12 = C_MIN;
                    hc.h20 = C_MAX;
                    hc.h21 = C_MIN;
                    span = 1023;
                end
                5:  // projective term hits zero at row 1
                begin
                    hc.h20 = C_NEG_ONE;
                    span = 3;
                end
                6:  // negative coordinates near the origin
                begin
                    hc.h02 = 48'hFFF6_0000_0000;
                    hc.h12 = 48'hFFFF_8000_0000;
                    span = 31;
                end
                7:  // tiny perspective with edge offsets
                begin
                    hc.h02 = 48'h0000_0000_0001;
                    hc.h21 = 48'h0000_0000_0001;
                    hc.h12 = 48'h00FE_FFFF_FFFF;
                    span = 7;
                end
                default: ;
            endcase
            apply_homog(hc);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 60;
                end
                default:
                begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
            endcase

            if (ph == 0)
            begin
                // corners, edges, clamp row/col 255, out-of-image coords
                put_sample(10'd0, 10'd0, sent);
                put_sample(10'd255, 10'd255, sent);
                put_sample(10'd255, 10'd0, sent);
                put_sample(10'd0, 10'd255, sent);
                put_sample(10'd256, 10'd0, sent);
                put_sample(10'd0, 10'd256, sent);
                put_sample(10'd1023, 10'd1023, sent);
                put_load(8'd0, 8'd0, 24'h000000);
                put_load(8'd255, 8'd255, 24'hFFFFFF);
                put_load(8'd0, 8'd255, 24'hFF00FF);
                put_sample(10'd0, 10'd0, sent);
                put_sample(10'd255, 10'd255, sent);
                put_sample(10'd0, 10'd255, sent);
            end
            if (ph == 0)
                hold_request++;   // receiver holds off while items keep coming

            made = 0;
            tries = 0;
            while (made < PHASE_ITEMS && tries < MAX_TRIES)
            begin
                tries++;
                if ($urandom_range(3) == 0)
                begin
                    put_load(8'($urandom), 8'($urandom), 24'($urandom));
                    sent = 1'b1;
                end
                else if ($urandom_range(3) == 0)
                    put_sample(10'($urandom), 10'($urandom), sent);
                else
                    put_sample(10'($urandom_range(span)), 10'($urandom_range(span)), sent);
                if (sent)
                    made++;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("perspective_warp_bilinear_sampler: match");
        else
            $display("perspective_warp_bilinear_sampler: mismatch");
        $finish;
    end

endmodule
